>>> hw/rtl/nirt_pkg.sv
// Shared types, register map, reset values and helpers for the NEC infrared frame transmitter.
package nirt_pkg;

    // Default number of data bits in one frame.
    localparam int FRAME_BITS_DEF = 32;

    // Widths of the timing values.
    localparam int MARK_W    = 16;
    localparam int TRAILER_W = 17;
    localparam int CARRIER_W = 8;

    // APB data and address widths.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;

    // Input item kinds carried in the slave tuser bit.
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Register reset values.
    localparam logic [MARK_W-1:0]    LEADER_MARK_RST   = 16'd9000;
    localparam logic [MARK_W-1:0]    LEADER_SPACE_RST  = 16'd4500;
    localparam logic [MARK_W-1:0]    BIT_MARK_RST      = 16'd560;
    localparam logic [MARK_W-1:0]    ZERO_SPACE_RST    = 16'd560;
    localparam logic [MARK_W-1:0]    ONE_SPACE_RST     = 16'd1680;
    localparam logic [TRAILER_W-1:0] TRAILER_SPACE_RST = 17'd63000;
    localparam logic [CARRIER_W-1:0] CARRIER_HALF_RST  = 8'd13;

    // Register indexes, at byte address 4 * index.
    typedef enum logic [2:0] {
        REG_LEADER_MARK   = 3'd0,
        REG_LEADER_SPACE  = 3'd1,
        REG_BIT_MARK      = 3'd2,
        REG_ZERO_SPACE    = 3'd3,
        REG_ONE_SPACE     = 3'd4,
        REG_TRAILER_SPACE = 3'd5,
        REG_CARRIER_HALF  = 3'd6
    } reg_idx_t;

    // Frame phases.
    typedef enum logic [2:0] {
        PH_IDLE        = 3'd0,
        PH_LEAD_MARK   = 3'd1,
        PH_LEAD_SPACE  = 3'd2,
        PH_BIT_MARK    = 3'd3,
        PH_BIT_SPACE   = 3'd4,
        PH_STOP_MARK   = 3'd5,
        PH_TRAILER     = 3'd6
    } phase_t;

    // True for phases that send carrier.
    function automatic logic is_mark(input phase_t p);
        return (p == PH_LEAD_MARK) || (p == PH_BIT_MARK) || (p == PH_STOP_MARK);
    endfunction

    // A length of zero counts as one tick.
    function automatic logic [TRAILER_W-1:0] at_least_one(input logic [TRAILER_W-1:0] v);
        return (v == '0) ? TRAILER_W'(1) : v;
    endfunction

endpackage

>>> hw/rtl/nec_ir_frame_transmitter.sv
// A result beat is registered: it appears on the master side in the cycle after its input beat is taken.
// Throughput: one input beat per cycle; each beat is a single counter step on registered state.
// The only stall is backpressure: a held result beat blocks the input until it is taken.
// Reset (rst_n low, asynchronous) returns the frame state machine to idle, empties the result
// register and loads every timing register with its NEC default (9 ms leader, 38 kHz carrier).
// No clearing pass is needed after reset.
module nec_ir_frame_transmitter #(
    parameter int FRAME_BITS = nirt_pkg::FRAME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,

    // Input beats.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [15:0]                      s_axis_tdata,   // [7:0] address, [15:8] command
    input  logic                             s_axis_tuser,   // [0] op: 0 tick, 1 start

    // Result beats.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [7:0]                       m_axis_tdata,   // [0] ir_out, [1] busy_res, [7:2] zero
    output logic                             m_axis_tlast,   // frame_done

    // Configuration port.
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [nirt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [nirt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nirt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int BIW = $clog2(FRAME_BITS);
    localparam logic [BIW-1:0] LAST_BIT = BIW'(FRAME_BITS - 1);

    // ---------------------------------------------------------------------------------------
    // Configuration registers. pready is tied high, so every access completes in its
    // access cycle. Writes to addresses past the last register are dropped.
    // ---------------------------------------------------------------------------------------
    logic [nirt_pkg::MARK_W-1:0]    leader_mark_reg;
    logic [nirt_pkg::MARK_W-1:0]    leader_space_reg;
    logic [nirt_pkg::MARK_W-1:0]    bit_mark_reg;
    logic [nirt_pkg::MARK_W-1:0]    zero_space_reg;
    logic [nirt_pkg::MARK_W-1:0]    one_space_reg;
    logic [nirt_pkg::TRAILER_W-1:0] trailer_space_reg;
    logic [nirt_pkg::CARRIER_W-1:0] carrier_half_reg;

    nirt_pkg::reg_idx_t reg_idx;
    logic               cfg_write;

    assign pready    = 1'b1;
    assign reg_idx   = nirt_pkg::reg_idx_t'(paddr[4:2]);
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            leader_mark_reg   <= nirt_pkg::LEADER_MARK_RST;
            leader_space_reg  <= nirt_pkg::LEADER_SPACE_RST;
            bit_mark_reg      <= nirt_pkg::BIT_MARK_RST;
            zero_space_reg    <= nirt_pkg::ZERO_SPACE_RST;
            one_space_reg     <= nirt_pkg::ONE_SPACE_RST;
            trailer_space_reg <= nirt_pkg::TRAILER_SPACE_RST;
            carrier_half_reg  <= nirt_pkg::CARRIER_HALF_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                nirt_pkg::REG_LEADER_MARK:   leader_mark_reg   <= pwdata[15:0];
                nirt_pkg::REG_LEADER_SPACE:  leader_space_reg  <= pwdata[15:0];
                nirt_pkg::REG_BIT_MARK:      bit_mark_reg      <= pwdata[15:0];
                nirt_pkg::REG_ZERO_SPACE:    zero_space_reg    <= pwdata[15:0];
                nirt_pkg::REG_ONE_SPACE:     one_space_reg     <= pwdata[15:0];
                nirt_pkg::REG_TRAILER_SPACE: trailer_space_reg <= pwdata[16:0];
                nirt_pkg::REG_CARRIER_HALF:  carrier_half_reg  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Read data is a plain decode of the register bank.
    always_comb
    begin
        unique case (reg_idx)
            nirt_pkg::REG_LEADER_MARK:   prdata = 32'(leader_mark_reg);
            nirt_pkg::REG_LEADER_SPACE:  prdata = 32'(leader_space_reg);
            nirt_pkg::REG_BIT_MARK:      prdata = 32'(bit_mark_reg);
            nirt_pkg::REG_ZERO_SPACE:    prdata = 32'(zero_space_reg);
            nirt_pkg::REG_ONE_SPACE:     prdata = 32'(one_space_reg);
            nirt_pkg::REG_TRAILER_SPACE: prdata = 32'(trailer_space_reg);
            nirt_pkg::REG_CARRIER_HALF:  prdata = 32'(carrier_half_reg);
            default:                     prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------------------------
    // Handshake. The result register parts the two sides: a new beat is taken whenever the
    // result register is empty or is being emptied in the same cycle.
    // ---------------------------------------------------------------------------------------
    logic out_valid_reg;
    logic s_accept;

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign s_accept      = s_axis_tvalid & s_axis_tready;

    // ---------------------------------------------------------------------------------------
    // Frame state. Each accepted beat advances the state by at most one tick.
    // ---------------------------------------------------------------------------------------
    nirt_pkg::phase_t               phase_reg,         phase_next;
    logic [nirt_pkg::TRAILER_W-1:0] ticks_left_reg,    ticks_left_next;
    logic [BIW-1:0]                 bit_index_reg,     bit_index_next;
    logic [FRAME_BITS-1:0]          frame_shift_reg,   frame_shift_next;
    logic [nirt_pkg::CARRIER_W-1:0] carrier_count_reg, carrier_count_next;
    logic                           carrier_level_reg, carrier_level_next;
    logic                           done_next;

    // Phase entry request, applied after the tick logic.
    logic                           do_enter;
    nirt_pkg::phase_t               enter_phase;
    logic [nirt_pkg::TRAILER_W-1:0] enter_len;

    logic [nirt_pkg::TRAILER_W-1:0] ticks_dec;
    logic [nirt_pkg::CARRIER_W-1:0] count_inc;
    logic [nirt_pkg::CARRIER_W-1:0] half_eff;
    logic [31:0]                    frame_word;
    logic [FRAME_BITS+31:0]         frame_wide;

    // The 32-bit word is address, inverted address, command, inverted command from the low
    // byte up. It is zero extended or cut to the frame length.
    assign frame_word = {~s_axis_tdata[15:8], s_axis_tdata[15:8],
                         ~s_axis_tdata[7:0],  s_axis_tdata[7:0]};
    assign frame_wide = {{FRAME_BITS{1'b0}}, frame_word};

    assign ticks_dec = (ticks_left_reg != '0) ? ticks_left_reg - 17'd1 : ticks_left_reg;
    assign count_inc = carrier_count_reg + 8'd1;
    assign half_eff  = (carrier_half_reg == '0) ? 8'd1 : carrier_half_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        ticks_left_next    = ticks_left_reg;
        bit_index_next     = bit_index_reg;
        frame_shift_next   = frame_shift_reg;
        carrier_count_next = carrier_count_reg;
        carrier_level_next = carrier_level_reg;
        done_next          = 1'b0;
        do_enter           = 1'b0;
        enter_phase        = nirt_pkg::PH_IDLE;
        enter_len          = '0;

        if (s_accept)
        begin
            if (s_axis_tuser == nirt_pkg::OP_START)
            begin
                // A start during a frame is dropped and the current outputs are repeated.
                if (phase_reg == nirt_pkg::PH_IDLE)
                begin
                    frame_shift_next = frame_wide[FRAME_BITS-1:0];
                    bit_index_next   = '0;
                    do_enter         = 1'b1;
                    enter_phase      = nirt_pkg::PH_LEAD_MARK;
                    enter_len        = nirt_pkg::at_least_one(17'(leader_mark_reg));
                end
            end
            else if (phase_reg != nirt_pkg::PH_IDLE)
            begin
                // Carrier divider runs only while a mark is on the air.
                if (nirt_pkg::is_mark(phase_reg))
                begin
                    carrier_count_next = count_inc;
                    if (count_inc >= half_eff)
                    begin
                        carrier_level_next = ~carrier_level_reg;
                        carrier_count_next = '0;
                    end
                end

                ticks_left_next = ticks_dec;
                if (ticks_dec == '0)
                begin
                    do_enter = 1'b1;
                    unique case (phase_reg)
                        nirt_pkg::PH_LEAD_MARK:
                        begin
                            enter_phase = nirt_pkg::PH_LEAD_SPACE;
                            enter_len   = nirt_pkg::at_least_one(17'(leader_space_reg));
                        end
                        nirt_pkg::PH_LEAD_SPACE:
                        begin
                            enter_phase = nirt_pkg::PH_BIT_MARK;
                            enter_len   = nirt_pkg::at_least_one(17'(bit_mark_reg));
                        end
                        nirt_pkg::PH_BIT_MARK:
                        begin
                            enter_phase = nirt_pkg::PH_BIT_SPACE;
                            enter_len   = nirt_pkg::at_least_one(frame_shift_reg[0]
                                              ? 17'(one_space_reg) : 17'(zero_space_reg));
                        end
                        nirt_pkg::PH_BIT_SPACE:
                        begin
                            frame_shift_next = frame_shift_reg >> 1;
                            bit_index_next   = bit_index_reg + BIW'(1);
                            enter_len        = nirt_pkg::at_least_one(17'(bit_mark_reg));
                            if (bit_index_reg == LAST_BIT)
                            begin
                                enter_phase = nirt_pkg::PH_STOP_MARK;
                            end
                            else
                            begin
                                enter_phase = nirt_pkg::PH_BIT_MARK;
                            end
                        end
                        nirt_pkg::PH_STOP_MARK:
                        begin
                            // With no trailer the frame closes as the stop mark ends.
                            if (trailer_space_reg == '0)
                            begin
                                enter_phase = nirt_pkg::PH_IDLE;
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                enter_phase = nirt_pkg::PH_TRAILER;
                                enter_len   = trailer_space_reg;
                            end
                        end
                        default:
                        begin
                            enter_phase = nirt_pkg::PH_IDLE;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end
        end

        // Entering a mark restarts the carrier high; entering a space forces it low.
        if (do_enter)
        begin
            phase_next      = enter_phase;
            ticks_left_next = enter_len;
            if (nirt_pkg::is_mark(enter_phase))
            begin
                carrier_level_next = 1'b1;
                carrier_count_next = '0;
            end
            else
            begin
                carrier_level_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= nirt_pkg::PH_IDLE;
            ticks_left_reg    <= '0;
            bit_index_reg     <= '0;
            frame_shift_reg   <= '0;
            carrier_count_reg <= '0;
            carrier_level_reg <= 1'b0;
        end
        else
        begin
            phase_reg         <= phase_next;
            ticks_left_reg    <= ticks_left_next;
            bit_index_reg     <= bit_index_next;
            frame_shift_reg   <= frame_shift_next;
            carrier_count_reg <= carrier_count_next;
            carrier_level_reg <= carrier_level_next;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Result register. It shows the state after the beat that produced it.
    // ---------------------------------------------------------------------------------------
    logic ir_reg, busy_reg, done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            ir_reg   <= nirt_pkg::is_mark(phase_next) & carrier_level_next;
            busy_reg <= (phase_next != nirt_pkg::PH_IDLE);
            done_reg <= done_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, busy_reg, ir_reg};
    assign m_axis_tlast  = done_reg;

endmodule

>>> hw/rtl/nirt_checker.sv
// Port-level checker for the NEC infrared frame transmitter and its bind statement.
module nirt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast
);

    // The emitter only lights while a frame is in progress.
    a_ir_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[1])
        else $error("ir_out high outside a frame");

    // The beat that closes a frame already shows the block idle.
    a_done_is_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> !m_axis_tdata[1])
        else $error("frame_done while still busy");

    // Every taken input beat yields a result beat in the next cycle.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("input beat without result beat");

    // Input is ready whenever the result side is not stalled.
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !(m_axis_tvalid && !m_axis_tready) |-> s_axis_tready)
        else $error("input stalled while result side is free");

    // A stalled result beat holds.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result beat changed");

endmodule

bind nec_ir_frame_transmitter nirt_checker u_nirt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
